// File: src/cdq_pkg.sv
// Shared types, constants and helpers for the circular deque.
package cdq_pkg;

  // Ring geometry
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int MOD_W  = $clog2(DEPTH + 2);
  localparam int DATA_W = 32;
  localparam int OUT_CNT_W = 7;
  localparam int STEP_W = $clog2(DATA_W);

  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [ADDR_W:0]   DEPTH_X   = (ADDR_W + 1)'(DEPTH);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic [MOD_W-1:0]         mod_t;

  // Operation codes
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_FIND       = 3'd4,
    OP_CREATE     = 3'd5
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // (a + b) mod DEPTH for a, b below DEPTH
  function automatic addr_t wrap_add(input addr_t a, input addr_t b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_X) s = s - DEPTH_X;
    return s[ADDR_W-1:0];
  endfunction

endpackage

// File: src/cdq_if.sv
// Valid/ready channel interfaces for deque commands and results.
interface cdq_in_if;
  import cdq_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  data_t      value;
  data_t      offset;
  modport source (output valid, operation, value, offset, input ready);
  modport sink   (input valid, operation, value, offset, output ready);
endinterface

interface cdq_out_if;
  import cdq_pkg::*;
  logic                 valid;
  logic                 ready;
  data_t                read_value;
  logic [1:0]           status;
  logic [OUT_CNT_W-1:0] entry_count;
  modport source (output valid, read_value, status, entry_count, input ready);
  modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface

// File: src/circular_deque_with_offset_read.sv
// Top level of the bounded circular deque with offset read.
//
// A bounded deque of up to 64 entries kept in a RAM ring around a head value.
// Push, pop and create are accepted, then their result goes from an emit state
// to the output register. Find runs a one-bit-per-cycle restoring divider that
// reduces the offset modulo count+1; a lookup state forms the ring index, and a
// fetch state reads a non-head entry through the registered port. The block takes
// one transaction at a time; a finished result sits in an output register, so
// the next command is accepted while the previous result waits to be taken.
// The store needs no clearing after reset.
module circular_deque_with_offset_read (
  input logic   clk,
  input logic   rst_n,
  cdq_in_if.sink    in_ch,
  cdq_out_if.source out_ch
);
  import cdq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_LOOK  = 5'b00100,
    S_FETCH = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t      state_r, state_nxt;
  addr_t       front_r, front_nxt;
  count_t      count_r, count_nxt;
  data_t       head_r, head_nxt;
  // divider
  logic [DATA_W-1:0] dvd_r, dvd_nxt;
  mod_t        rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic        neg_r, neg_nxt;
  // pending result
  data_t       res_value_r, res_value_nxt;
  status_t     res_status_r, res_status_nxt;
  // output register
  logic        out_valid_r, out_valid_nxt;
  data_t       out_value_r, out_value_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [OUT_CNT_W-1:0] out_count_r, out_count_nxt;

  logic        accept;
  logic        emit_go;
  mod_t        modulus;
  logic [MOD_W:0] trial;
  mod_t        pos;
  mod_t        pos_m1;
  logic [CNT_W+OUT_CNT_W-1:0] count_ext;
  logic        ram_we;
  addr_t       ram_waddr;
  addr_t       ram_raddr;
  data_t       ram_rdata;
  logic [DATA_W-1:0] off_mag;

  cdq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake and shared datapath terms
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign emit_go     = !out_valid_r || out_ch.ready;
  assign modulus     = MOD_W'(count_r) + MOD_W'(1);
  assign trial       = {rem_r, dvd_r[DATA_W-1]};
  assign pos         = (neg_r && (rem_r != '0)) ? (modulus - rem_r) : rem_r;
  assign pos_m1      = pos - MOD_W'(1);
  assign ram_raddr   = wrap_add(front_r, pos_m1[ADDR_W-1:0]);
  assign count_ext   = {{OUT_CNT_W{1'b0}}, count_r};
  assign off_mag     = in_ch.offset[DATA_W-1] ? (~in_ch.offset + DATA_W'(1))
                                              : in_ch.offset;

  // Sequencer and next-state logic
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    head_nxt       = head_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    step_nxt       = step_r;
    neg_nxt        = neg_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = (front_r == '0) ? LAST_SLOT : (front_r - ADDR_W'(1));

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_value_nxt  = '0;
          res_status_nxt = ST_OK;
          state_nxt      = S_EMIT;
          unique case (in_ch.operation)
            OP_PUSH_FRONT: begin
              if (count_r == FULL_CNT) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                front_nxt = ram_waddr;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_PUSH_BACK: begin
              ram_waddr = wrap_add(front_r, count_r[ADDR_W-1:0]);
              if (count_r == FULL_CNT) begin
                res_status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_POP_FRONT: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                front_nxt = wrap_add(front_r, ADDR_W'(1));
                count_nxt = count_r - CNT_W'(1);
              end
            end
            OP_POP_BACK: begin
              if (count_r == '0) res_status_nxt = ST_EMPTY;
              else count_nxt = count_r - CNT_W'(1);
            end
            OP_FIND: begin
              dvd_nxt   = off_mag;
              rem_nxt   = '0;
              step_nxt  = '0;
              neg_nxt   = in_ch.offset[DATA_W-1];
              state_nxt = S_DIV;
            end
            OP_CREATE: begin
              count_nxt = '0;
              front_nxt = '0;
              head_nxt  = in_ch.value;
            end
            default: ;
          endcase
        end
      end
      // One restoring step per cycle: remainder of |offset| by count+1
      S_DIV: begin
        if (trial >= {1'b0, modulus}) rem_nxt = MOD_W'(trial - {1'b0, modulus});
        else rem_nxt = trial[MOD_W-1:0];
        dvd_nxt  = {dvd_r[DATA_W-2:0], 1'b0};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) state_nxt = S_LOOK;
      end
      // Ring position 0 is the head; others come from the store
      S_LOOK: begin
        if (pos == '0) begin
          res_value_nxt = head_r;
          state_nxt     = S_EMIT;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        res_value_nxt = ram_rdata;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = count_ext[OUT_CNT_W-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and payload registers
  always_ff @(posedge clk) begin
    dvd_r        <= dvd_nxt;
    rem_r        <= rem_nxt;
    step_r       <= step_nxt;
    neg_r        <= neg_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_value  = out_value_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_count = out_count_r;

`ifndef SYNTHESIS
  // Count never exceeds the ring depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count above depth");

  // A push onto a full ring leaves the count alone
  a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && count_r == FULL_CNT &&
     (in_ch.operation == OP_PUSH_FRONT || in_ch.operation == OP_PUSH_BACK))
    |=> count_r == $past(count_r))
    else $error("push on full ring changed count");

  // Divider remainder stays below the modulus
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < modulus)
    else $error("divider remainder out of range");

  // A store fetch only follows the lookup step
  a_fetch_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FETCH |-> $past(state_r) == S_LOOK)
    else $error("store fetch without lookup");
`endif

endmodule

// File: src/cdq_ram.sv
// Generic simple dual-port RAM with registered read data.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: bench/tb_circular_deque_with_offset_read.sv
// Self-checking testbench for the circular deque: directed, fill/drain, random, backpressure.
module tb_circular_deque_with_offset_read;
  import cdq_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLD_CYCLES    = 400;

  // Codes with no operation behind them
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam data_t DATA_MAX = 32'sh7fffffff;
  localparam data_t DATA_MIN = 32'sh80000000;

  typedef struct packed {
    data_t                read_value;
    logic [1:0]           status;
    logic [OUT_CNT_W-1:0] entry_count;
  } deque_result_t;

  logic clk;
  logic rst_n;

  cdq_in_if  in_ch();
  cdq_out_if out_ch();

  circular_deque_with_offset_read DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the deque
  data_t ring_model [DEPTH];
  addr_t front_model;
  int    count_model;
  data_t head_model;

  deque_result_t pending_results[$];

  int error_count = 0;
  int idle_pct;
  int stall_pct;
  int hold_request;
  int hold_taken;
  int hold_left;
  int quiet_cycles = 0;

  // Clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Apply one command to the shadow deque and return the result it should give
  function automatic deque_result_t deque_apply(input logic [2:0] op, input data_t val,
                                                input data_t off);
    deque_result_t r;
    longint m;
    longint p;
    r.read_value = '0;
    r.status     = ST_OK;
    case (op)
      OP_PUSH_FRONT: begin
        if (count_model >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          front_model = addr_t'((front_model + DEPTH - 1) % DEPTH);
          ring_model[front_model] = val;
          count_model++;
        end
      end
      OP_PUSH_BACK: begin
        if (count_model >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_model[(front_model + count_model) % DEPTH] = val;
          count_model++;
        end
      end
      OP_POP_FRONT: begin
        if (count_model == 0) begin
          r.status = ST_EMPTY;
        end else begin
          front_model = addr_t'((front_model + 1) % DEPTH);
          count_model--;
        end
      end
      OP_POP_BACK: begin
        if (count_model == 0) r.status = ST_EMPTY;
        else count_model--;
      end
      OP_FIND: begin
        // Ring position modulo count+1, head at position 0
        m = count_model + 1;
        p = longint'(off) % m;
        if (p < 0) p = p + m;
        if (p == 0) r.read_value = head_model;
        else r.read_value = ring_model[(front_model + p - 1) % DEPTH];
      end
      OP_CREATE: begin
        count_model = 0;
        front_model = '0;
        head_model  = val;
      end
      default: ;
    endcase
    r.entry_count = OUT_CNT_W'(count_model);
    return r;
  endfunction

  // Offer one command, idling first at random; record its result once accepted
  task automatic send_cmd(input logic [2:0] op, input data_t val, input data_t off);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid     <= 1'b0;
      in_ch.operation <= 3'($urandom);
      in_ch.value     <= $urandom;
      in_ch.offset    <= $urandom;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.value     <= val;
    in_ch.offset    <= off;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.push_back(deque_apply(op, val, off));
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    hold_taken   = 0;
    forever begin
      @(negedge clk);
      if (hold_request != hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = hold_request;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    deque_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result read_value %h status %0d entry_count %0d",
                 $time, out_ch.read_value, out_ch.status, out_ch.entry_count);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.read_value !== want.read_value) begin
          error_count++;
          $display("%0t: read_value mismatch expected %h actual %h",
                   $time, want.read_value, out_ch.read_value);
        end
        if (out_ch.status !== want.status) begin
          error_count++;
          $display("%0t: status mismatch expected %0d actual %0d",
                   $time, want.status, out_ch.status);
        end
        if (out_ch.entry_count !== want.entry_count) begin
          error_count++;
          $display("%0t: entry_count mismatch expected %0d actual %0d",
                   $time, want.entry_count, out_ch.entry_count);
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // Edges of the fields, empty pops, finds around the ring, spare codes
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_cmd(OP_CREATE, DATA_MIN, '0);
    send_cmd(OP_FIND, '0, '0);
    send_cmd(OP_FIND, '0, DATA_MAX);
    send_cmd(OP_FIND, '0, DATA_MIN);
    send_cmd(OP_POP_FRONT, $urandom, $urandom);
    send_cmd(OP_POP_BACK, $urandom, $urandom);
    send_cmd(OP_PUSH_FRONT, DATA_MAX, '0);
    send_cmd(OP_PUSH_BACK, DATA_MIN, '0);
    send_cmd(OP_PUSH_FRONT, '0, DATA_MAX);
    send_cmd(OP_PUSH_BACK, -32'sd1, DATA_MIN);
    send_cmd(OP_FIND, '0, 32'sd1);
    send_cmd(OP_FIND, '0, -32'sd1);
    send_cmd(OP_FIND, '0, 32'sd5);
    send_cmd(OP_FIND, '0, -32'sd5);
    send_cmd(OP_FIND, DATA_MAX, DATA_MAX);
    send_cmd(OP_FIND, DATA_MIN, DATA_MIN);
    send_cmd(OP_SPARE_LO, $urandom, $urandom);
    send_cmd(OP_SPARE_HI, $urandom, $urandom);
    send_cmd(OP_POP_FRONT, '0, '0);
    send_cmd(OP_POP_BACK, '0, '0);
    send_cmd(OP_FIND, '0, 32'sd2);
    send_cmd(OP_CREATE, DATA_MAX, '0);
    send_cmd(OP_FIND, '0, 32'sd3);
  endtask

  // Fill to capacity, push past it, read the wrap points, drain past empty
  task automatic test_fill_and_drain();
    idle_pct  = 0;
    stall_pct = 0;
    send_cmd(OP_CREATE, $urandom, '0);
    for (int i = 0; i < DEPTH; i++)
      send_cmd(($urandom_range(1) == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom, $urandom);
    send_cmd(OP_PUSH_FRONT, $urandom, '0);
    send_cmd(OP_PUSH_BACK, $urandom, '0);
    send_cmd(OP_FIND, '0, 32'(DEPTH));
    send_cmd(OP_FIND, '0, 32'(DEPTH + 1));
    send_cmd(OP_FIND, '0, -32'sd1);
    send_cmd(OP_FIND, '0, -32'(DEPTH + 1));
    for (int i = 0; i < DEPTH + 2; i++)
      send_cmd(($urandom_range(1) == 0) ? OP_POP_FRONT : OP_POP_BACK, '0, '0);
  endtask

  // Random command mix that sweeps the count between empty and full
  task automatic test_random_mix(input int n_items, input int idle, input int stall);
    bit grow;
    int r;
    int s;
    int m;
    logic [2:0] op;
    data_t val;
    data_t off;
    idle_pct  = idle;
    stall_pct = stall;
    grow      = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      // Turn around at the ends, lingering a little to hit full and empty
      if (grow && count_model >= DEPTH && $urandom_range(3) == 0) grow = 1'b0;
      if (!grow && count_model == 0 && $urandom_range(3) == 0) grow = 1'b1;
      if ($urandom_range(199) == 0) grow = ~grow;
      r = $urandom_range(99);
      if (r < 2) op = OP_CREATE;
      else if (r < 4) op = ($urandom_range(1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
      else if (r < (grow ? 50 : 20))
        op = ($urandom_range(1) == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      else if (r < (grow ? 65 : 60))
        op = ($urandom_range(1) == 0) ? OP_POP_FRONT : OP_POP_BACK;
      else op = OP_FIND;
      case ($urandom_range(9))
        0:       val = DATA_MAX;
        1:       val = DATA_MIN;
        default: val = $urandom;
      endcase
      m = count_model + 1;
      s = $urandom_range(9);
      if (s <= 5) off = 32'($urandom_range(6 * m) - 3 * m);
      else if (s == 6) off = 32'(m * ($urandom_range(40) - 20));
      else if (s == 7) off = $urandom;
      else if (s == 8) off = ($urandom_range(1) == 0) ? DATA_MAX : DATA_MIN;
      else off = 32'($urandom_range(2) - 1);
      send_cmd(op, val, off);
    end
  endtask

  // Long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    hold_request++;
    for (int i = 0; i < 30; i++)
      send_cmd(($urandom_range(2) == 0) ? OP_FIND : OP_PUSH_BACK, $urandom,
               32'($urandom_range(8)));
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = '0;
    in_ch.value     = '0;
    in_ch.offset    = '0;
    idle_pct        = 0;
    stall_pct       = 0;
    hold_request    = 0;
    front_model     = '0;
    count_model     = 0;
    head_model      = '0;
    foreach (ring_model[i]) ring_model[i] = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill_and_drain();
    test_random_mix(400, 0, 0);
    test_random_mix(400, 76, 0);
    test_random_mix(400, 0, 76);
    test_random_mix(400, 25, 25);
    test_backpressure();

    // Drain outstanding results
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/cdq_pkg.sv
src/cdq_if.sv
src/cdq_ram.sv
src/circular_deque_with_offset_read.sv
bench/tb_circular_deque_with_offset_read.sv
